// ===== design/modexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

  // Fixed widths of the interface fields.
  localparam int DATA_W = 32;
  localparam int WORD_BITS_DEF = 32;

  // Register file of the configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER = 1'd1;

  localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd3233;
  localparam logic [DATA_W-1:0] POWER_RESET = 32'd17;

  // Which product the shared modular multiplier forms.
  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_ACC,
    OP_SQR
  } mul_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED_WAIT,
    ST_LOOP,
    ST_ACC_WAIT,
    ST_SQR_WAIT,
    ST_FINISH
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    start;
    mul_op_t op;
    logic    shift;
    logic    emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
    logic exp_zero;
    logic exp_lsb;
    logic n_small;
    logic out_full;
  } dp_stat_t;

endpackage

// ===== design/modexp_ctrl.sv =====
// Controller state machine that sequences square-and-multiply steps.
module modexp_ctrl
  import modexp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.op = OP_REDUCE;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.n_small) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.start = 1'b1;
          cmd.op = OP_REDUCE;
          state_nxt = ST_RED_WAIT;
        end
      end
      ST_RED_WAIT: begin
        if (!stat.busy) begin
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (stat.exp_zero) begin
          state_nxt = ST_FINISH;
        end else if (stat.exp_lsb) begin
          cmd.start = 1'b1;
          cmd.op = OP_ACC;
          state_nxt = ST_ACC_WAIT;
        end else begin
          cmd.start = 1'b1;
          cmd.op = OP_SQR;
          cmd.shift = 1'b1;
          state_nxt = ST_SQR_WAIT;
        end
      end
      ST_ACC_WAIT: begin
        if (!stat.busy) begin
          cmd.start = 1'b1;
          cmd.op = OP_SQR;
          cmd.shift = 1'b1;
          state_nxt = ST_SQR_WAIT;
        end
      end
      ST_SQR_WAIT: begin
        if (!stat.busy) begin
          state_nxt = ST_LOOP;
        end
      end
      ST_FINISH: begin
        if (!stat.out_full || !out_stall) begin
          cmd.emit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/modexp_dp.sv =====
// Datapath: operand registers, bit-serial modular multiplier and output register.
module modexp_dp
  import modexp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [WORD_BITS-1:0] cfg_n,
  input  logic [WORD_BITS-1:0] cfg_e,
  input  logic [WORD_BITS-1:0] base_in,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [DATA_W-1:0]    out_data
);

  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] n_r, exp_r, acc_r, sq_r, base_r;
  logic [WORD_BITS-1:0] ma_r, mb_r, mr_r;
  logic [CNT_W-1:0]     cnt_r;
  mul_op_t              op_r;
  logic                 run_r;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_data_r;

  // One multiplier step: r = (2r + bit * a) mod n, two compare-subtracts.
  logic [WORD_BITS:0]   n_ext, dbl, sum;
  logic [WORD_BITS-1:0] r1, mr_nxt;

  always_comb begin
    n_ext = {1'b0, n_r};
    dbl = {mr_r, 1'b0};
    r1 = (dbl >= n_ext) ? WORD_BITS'(dbl - n_ext) : dbl[WORD_BITS-1:0];
    sum = {1'b0, r1} + (mb_r[WORD_BITS-1] ? {1'b0, ma_r} : '0);
    mr_nxt = (sum >= n_ext) ? WORD_BITS'(sum - n_ext) : sum[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= cfg_n;
      exp_r <= cfg_e;
      base_r <= base_in;
      acc_r <= WORD_BITS'(1);
    end
    if (cmd.shift) begin
      exp_r <= exp_r >> 1;
    end
    if (cmd.start) begin
      mr_r <= '0;
      unique case (cmd.op)
        OP_REDUCE: begin
          ma_r <= WORD_BITS'(1);
          mb_r <= base_r;
        end
        OP_ACC: begin
          ma_r <= sq_r;
          mb_r <= acc_r;
        end
        OP_SQR: begin
          ma_r <= sq_r;
          mb_r <= sq_r;
        end
        default: begin
          ma_r <= sq_r;
          mb_r <= sq_r;
        end
      endcase
      op_r <= cmd.op;
    end else if (run_r) begin
      mr_r <= mr_nxt;
      mb_r <= mb_r << 1;
      if (cnt_r == CNT_W'(1)) begin
        if (op_r == OP_ACC) begin
          acc_r <= mr_nxt;
        end else begin
          sq_r <= mr_nxt;
        end
      end
    end
    if (cmd.emit) begin
      out_data_r <= stat.n_small ? '0 : DATA_W'(acc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(WORD_BITS);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.busy = run_r;
    stat.exp_zero = (exp_r == '0);
    stat.exp_lsb = exp_r[0];
    stat.n_small = (n_r[WORD_BITS-1:1] == '0);
    stat.out_full = out_valid_r;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // The multiplier always keeps its partial remainder and the accumulator reduced.
  a_partial_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (mr_r < n_r))
    else $error("partial remainder not below modulus");

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (acc_r < n_r))
    else $error("accumulator not below modulus");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !run_r)
    else $error("multiplication started while one is running");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result overwrote an untaken transaction");

endmodule

// ===== design/modular_exponentiation.sv =====
// Top level: configuration registers, controller and datapath of the modular exponentiator.
// Sequence: after acceptance the base is reduced modulo the modulus; then, for each exponent
// bit up to the highest set one, a multiply into the accumulator when that bit is one and a
// squaring; a modulus of zero or one skips the arithmetic and gives a zero result.
// Throughput: one transaction at a time on the shared multiplier; an untaken result holds it.
// Reset: synchronous, active low; the block comes up idle with modulus 3233 and power 17.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  // Input channel: one base value per transaction.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    in_base_value,
  // Result channel: one result per input transaction.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_mod_result
);

  // The configuration registers hold the full 32-bit values; only the low
  // WORD_BITS bits take part in the arithmetic.
  logic [DATA_W-1:0] modulus_r;
  logic [DATA_W-1:0] power_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
      power_r <= POWER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS: modulus_r <= cfg_wdata;
        REG_POWER:   power_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller walks the exponent from its least significant bit and
  // starts one modular multiplication at a time on the datapath.
  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath captures the operands when a transaction is accepted, so
  // the result register can still hold an untaken result meanwhile.
  modexp_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_n     (modulus_r[WORD_BITS-1:0]),
    .cfg_e     (power_r[WORD_BITS-1:0]),
    .base_in   (in_base_value[WORD_BITS-1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_mod_result)
  );

endmodule

// ===== tb/sv/tb_modular_exponentiation.sv =====
// Self-checking testbench for the modular exponentiation block: directed table plus random phases.
module tb_modular_exponentiation;
  import modexp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [DATA_W-1:0]    in_base_value;
  logic                 out_valid;
  logic                 out_stall;
  logic [DATA_W-1:0]    out_mod_result;

  modular_exponentiation i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_base_value  (in_base_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mod_result (out_mod_result)
  );

  // The testbench keeps its own copy of the two registers. They start at the
  // reset values and follow every write made on the configuration port.
  logic [DATA_W-1:0] cur_modulus = MODULUS_RESET;
  logic [DATA_W-1:0] cur_power   = POWER_RESET;

  // Results still owed by the block, oldest first. One is pushed for every
  // accepted input transaction and popped for every accepted result.
  logic [DATA_W-1:0] pending_results [$];
  logic [DATA_W-1:0] oldest_result;
  int                fail_count = 0;

  // When set, neither side inserts idle cycles. This holds for the tail of the run.
  bit calm = 1'b0;

  localparam int RANDOM_ITEMS = 280;
  localparam int CALM_ITEMS   = 30;

  // Directed stimulus. A row either writes a register or sends one base value.
  // Where the answer is obvious (the classic 61 x 53 key pair, all-ones
  // operands, Fermat's little theorem on a prime modulus, modulus one and
  // exponent zero) the expected result is typed in; otherwise the predictor
  // supplies it.
  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    value;
    logic                 typed;
    logic [DATA_W-1:0]    want;
  } row_t;

  localparam int N_ROWS = 34;

  row_t directed_rows [N_ROWS] = '{
    // Reset settings: modulus 3233, power 17.
    '{ROW_ITEM, REG_MODULUS, 32'd65,         1'b1, 32'd2790},
    '{ROW_ITEM, REG_MODULUS, 32'd0,          1'b1, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'd1,          1'b1, 32'd1},
    '{ROW_ITEM, REG_MODULUS, 32'd3233,       1'b1, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'd3232,       1'b1, 32'd3232},
    '{ROW_ITEM, REG_MODULUS, 32'hFFFF_FFFF,  1'b0, 32'd0},
    // The private exponent of the same key pair decrypts the result.
    '{ROW_CFG,  REG_POWER,   32'd2753,       1'b0, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'd2790,       1'b1, 32'd65},
    // Exponent zero.
    '{ROW_CFG,  REG_POWER,   32'd0,          1'b0, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'd12345,      1'b1, 32'd1},
    '{ROW_ITEM, REG_MODULUS, 32'd0,          1'b1, 32'd1},
    // Modulus one.
    '{ROW_CFG,  REG_MODULUS, 32'd1,          1'b0, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'hFFFF_FFFF,  1'b1, 32'd0},
    '{ROW_CFG,  REG_POWER,   32'hFFFF_FFFF,  1'b0, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'd7,          1'b1, 32'd0},
    // Largest modulus and largest exponent.
    '{ROW_CFG,  REG_MODULUS, 32'hFFFF_FFFF,  1'b0, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'hFFFF_FFFF,  1'b1, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE},
    '{ROW_ITEM, REG_MODULUS, 32'hA5A5_A5A5,  1'b0, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'h5A5A_5A5A,  1'b0, 32'd0},
    // Smallest modulus that still computes.
    '{ROW_CFG,  REG_MODULUS, 32'd2,          1'b0, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'd3,          1'b1, 32'd1},
    '{ROW_ITEM, REG_MODULUS, 32'h8000_0000,  1'b1, 32'd0},
    // Largest 32-bit prime with exponent p - 1.
    '{ROW_CFG,  REG_MODULUS, 32'hFFFF_FFFB,  1'b0, 32'd0},
    '{ROW_CFG,  REG_POWER,   32'hFFFF_FFFA,  1'b0, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'd2,          1'b1, 32'd1},
    '{ROW_ITEM, REG_MODULUS, 32'hFFFF_FFFF,  1'b1, 32'd1},
    '{ROW_ITEM, REG_MODULUS, 32'hFFFF_FFFB,  1'b1, 32'd0},
    // Exponent one leaves only the reduction of the base.
    '{ROW_CFG,  REG_POWER,   32'd1,          1'b0, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'hFFFF_FFFF,  1'b1, 32'd4},
    '{ROW_CFG,  REG_MODULUS, 32'd65536,      1'b0, 32'd0},
    '{ROW_CFG,  REG_POWER,   32'd2,          1'b0, 32'd0},
    '{ROW_ITEM, REG_MODULUS, 32'h0000_FFFF,  1'b1, 32'd1},
    '{ROW_ITEM, REG_MODULUS, 32'h1234_5678,  1'b0, 32'd0}
  };

  // One modular product. Both operands are below 2^32, so the product is exact in 64 bits.
  function automatic logic [DATA_W-1:0] mul_mod(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b,
                                                input logic [DATA_W-1:0] n);
    logic [2*DATA_W-1:0] prod;
    prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    return DATA_W'(prod % {{DATA_W{1'b0}}, n});
  endfunction

  // Right-to-left square and multiply. A modulus of one (or zero) yields zero.
  function automatic logic [DATA_W-1:0] mod_power(input logic [DATA_W-1:0] base,
                                                  input logic [DATA_W-1:0] expo,
                                                  input logic [DATA_W-1:0] n);
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] sq;
    logic [DATA_W-1:0] bits_left;
    if (n <= 1) return '0;
    acc = 1;
    sq = base % n;
    bits_left = expo;
    while (bits_left != 0) begin
      if (bits_left[0]) acc = mul_mod(acc, sq, n);
      bits_left = bits_left >> 1;
      sq = mul_mod(sq, sq, n);
    end
    return acc;
  endfunction

  // Clock with a 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #80_000_000;
    $display("** modular_exponentiation: FAILED **");
    $finish;
  end

  // The result side stalls in random bursts, except in the calm tail.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && !calm && $urandom_range(0, 15) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result is compared with the oldest outstanding expectation.
  // Signals are read at the clock edge, before any update of this edge lands.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none outstanding: expected none, got %h",
                 $time, out_mod_result);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_mod_result !== oldest_result) begin
          $display("%0t: mod_result mismatch: expected %h, got %h",
                   $time, oldest_result, out_mod_result);
          fail_count++;
        end
      end
    end
  end

  // Writes one register. Registers only change while nothing is in flight, so
  // the input is held idle until every outstanding result has been taken.
  // The write enable stays high after the edge; the next transaction lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == REG_MODULUS) cur_modulus = value;
    else cur_power = value;
  endtask

  // Sends one base value, with an optional idle gap first, and records the
  // result it must produce once the block has taken it. Valid stays high on
  // return so that back-to-back transactions have no idle gap between them.
  task automatic send_base(input logic [DATA_W-1:0] base, input logic typed,
                           input logic [DATA_W-1:0] want);
    cfg_we <= 1'b0;
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_base_value <= base;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.insert(pending_results.size(),
                           typed ? want : mod_power(base, cur_power, cur_modulus));
  endtask

  function automatic logic [DATA_W-1:0] pick_modulus();
    case ($urandom_range(0, 11))
      0:       return 32'd1;
      1:       return 32'd2;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'hFFFF_FFFB;
      4:       return $urandom_range(3, 255);
      5:       return $urandom_range(256, 65535);
      6:       return 32'h8000_0000 | $urandom;
      default: return $urandom_range(2, 32'hFFFF_FFFF);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_power();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom_range(2, 63);
      4:       return $urandom_range(64, 65535);
      default: return $urandom;
    endcase
  endfunction

  // Bases cluster around the modulus as well as the ends of the range, since
  // the reduction step is where wrap-around mistakes tend to hide.
  function automatic logic [DATA_W-1:0] pick_base();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return cur_modulus - 1;
      3:       return cur_modulus;
      4:       return cur_modulus + 1;
      5:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int random_sent;
    int phase_len;
    random_sent = 0;

    // Every input is known from time zero.
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_MODULUS;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_base_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CFG)
        write_reg(directed_rows[r].idx, directed_rows[r].value);
      else
        send_base(directed_rows[r].value, directed_rows[r].typed, directed_rows[r].want);
    end

    // Random phases: each picks new register values while idle, then streams
    // a batch of bases through that setting.
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_MODULUS, pick_modulus());
        write_reg(REG_POWER, pick_power());
      end else begin
        write_reg(REG_POWER, pick_power());
        write_reg(REG_MODULUS, pick_modulus());
      end
      phase_len = $urandom_range(4, 20);
      for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
        calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
        send_base(pick_base(), 1'b0, '0);
        random_sent++;
      end
    end

    // Drain, then watch for stray results a little longer than one slow exponentiation.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("** modular_exponentiation: PASSED **");
    end else begin
      $display("** modular_exponentiation: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/modexp_pkg.sv
design/modexp_ctrl.sv
design/modexp_dp.sv
design/modular_exponentiation.sv
tb/sv/tb_modular_exponentiation.sv
